FILE: hdl/mpbm_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the multi-pattern byte matcher
package mpbm_pkg;

	localparam int NODE_COUNT = 1024;
	localparam int SIG_COUNT  = 16;
	localparam int ALPHABET   = 256;

	localparam int NODE_W    = 10;
	localparam int BYTE_W    = 8;
	localparam int SIG_W     = 4;
	localparam int GOTO_AW   = NODE_W + BYTE_W;
	localparam int GOTO_DEPTH = NODE_COUNT * ALPHABET;

	localparam int RES_DEPTH = 4;
	localparam int RES_PW    = $clog2(RES_DEPTH);
	localparam int RES_CW    = $clog2(RES_DEPTH + 1);

	localparam logic [1:0] FN_LOAD_GOTO = 2'd0;
	localparam logic [1:0] FN_LOAD_OUT  = 2'd1;
	localparam logic [1:0] FN_BYTE      = 2'd2;

	typedef struct packed {
		logic [1:0]        func;
		logic [NODE_W-1:0] node;
		logic [BYTE_W-1:0] byte_value;
		logic [NODE_W-1:0] next_node;
		logic              sig_present;
		logic [SIG_W-1:0]  sig_value;
		logic              last_byte;
	} cmd_t;

	typedef struct packed {
		logic             matched;
		logic [SIG_W-1:0] match_sig;
	} res_t;

	typedef struct packed {
		logic             present;
		logic [SIG_W-1:0] sig;
	} node_out_t;

endpackage

FILE: hdl/multi_pattern_byte_matcher.sv
`timescale 1ns / 1ps
// multi-pattern byte matcher top level: goto table walk and signature tracking
// a packet's last byte passes the goto read, the node output read and the result queue before its result is valid
// throughput: one item per cycle while cmd_stall is low; the goto table read data feeds the next byte's address
// node output memory is read the cycle after the goto read, the hit is tracked one stage later
// reset: current node at the root, no hit recorded, pipeline and result queue empty
// goto table and node output memories are not cleared and must be loaded before use
module multi_pattern_byte_matcher (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  mpbm_pkg::cmd_t   cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output mpbm_pkg::res_t   res
);

	logic [mpbm_pkg::NODE_W-1:0] goto_mem [mpbm_pkg::GOTO_DEPTH];
	mpbm_pkg::node_out_t         out_mem  [mpbm_pkg::NODE_COUNT];

	logic                          accept;
	logic                          is_byte;
	logic                          goto_we;
	logic                          out_we;
	mpbm_pkg::node_out_t           out_wdata;
	logic [mpbm_pkg::NODE_W-1:0]   cur_node;
	logic [mpbm_pkg::GOTO_AW-1:0]  goto_waddr;
	logic [mpbm_pkg::GOTO_AW-1:0]  goto_raddr;

	logic                          v_s1;
	logic                          last_s1;
	logic [mpbm_pkg::NODE_W-1:0]   goto_rd_s1;
	logic                          v_s2;
	logic                          last_s2;
	mpbm_pkg::node_out_t           out_rd_s2;

	logic [mpbm_pkg::NODE_W-1:0]   cur_q;
	logic                          hit_q;
	logic [mpbm_pkg::SIG_W-1:0]    sig_q;

	logic                          node_hit;
	logic                          res_push;
	mpbm_pkg::res_t                res_item;
	logic [mpbm_pkg::RES_CW-1:0]   res_count;
	logic [mpbm_pkg::RES_CW-1:0]   reserved;

	assign reserved  = res_count + mpbm_pkg::RES_CW'(v_s1 && last_s1)
		+ mpbm_pkg::RES_CW'(v_s2 && last_s2);
	assign cmd_stall = (int'(reserved) >= mpbm_pkg::RES_DEPTH);
	assign accept    = cmd_valid && !cmd_stall;
	assign is_byte   = accept && (cmd.func == mpbm_pkg::FN_BYTE);

	assign goto_we = accept && (cmd.func == mpbm_pkg::FN_LOAD_GOTO)
		&& (int'(cmd.node) < mpbm_pkg::NODE_COUNT)
		&& (int'(cmd.next_node) < mpbm_pkg::NODE_COUNT);
	assign out_we = accept && (cmd.func == mpbm_pkg::FN_LOAD_OUT)
		&& (int'(cmd.node) < mpbm_pkg::NODE_COUNT)
		&& (!cmd.sig_present || (int'(cmd.sig_value) < mpbm_pkg::SIG_COUNT));

	always_comb begin
		out_wdata.present = cmd.sig_present;
		out_wdata.sig     = cmd.sig_present ? cmd.sig_value : '0;
	end

	// node after the newest byte, taken straight from the read data when one is in flight (the root after a last byte)
	assign cur_node   = v_s1 ? (last_s1 ? '0 : goto_rd_s1) : cur_q;
	assign goto_waddr = {cmd.node, cmd.byte_value};
	assign goto_raddr = {cur_node, cmd.byte_value};

	always_ff @(posedge clk) begin
		if (goto_we) begin
			goto_mem[goto_waddr] <= cmd.next_node;
		end
		if (is_byte) begin
			goto_rd_s1 <= goto_mem[goto_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (out_we) begin
			out_mem[cmd.node] <= out_wdata;
		end
		if (v_s1) begin
			out_rd_s2 <= out_mem[goto_rd_s1];
		end
	end

	assign node_hit = v_s2 && out_rd_s2.present && !hit_q;
	assign res_push = v_s2 && last_s2;

	always_comb begin
		res_item.matched   = hit_q || node_hit;
		res_item.match_sig = hit_q ? sig_q : (node_hit ? out_rd_s2.sig : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			v_s2    <= 1'b0;
			last_s2 <= 1'b0;
			cur_q   <= '0;
			hit_q   <= 1'b0;
			sig_q   <= '0;
		end else begin
			v_s1    <= is_byte;
			last_s1 <= is_byte && cmd.last_byte;
			v_s2    <= v_s1;
			last_s2 <= v_s1 && last_s1;
			cur_q   <= cur_node;
			if (v_s2) begin
				if (last_s2) begin
					hit_q <= 1'b0;
					sig_q <= '0;
				end else if (node_hit) begin
					hit_q <= 1'b1;
					sig_q <= out_rd_s2.sig;
				end
			end
		end
	end

	mpbm_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_item (res_item),
		.valid     (res_valid),
		.stall     (res_stall),
		.item      (res),
		.count     (res_count)
	);

endmodule

FILE: hdl/mpbm_res_fifo.sv
`timescale 1ns / 1ps
// result queue between the match pipeline and the result channel
module mpbm_res_fifo (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  mpbm_pkg::res_t             push_item,
	output logic                       valid,
	input  logic                       stall,
	output mpbm_pkg::res_t             item,
	output logic [mpbm_pkg::RES_CW-1:0] count
);

	mpbm_pkg::res_t                slot_q [mpbm_pkg::RES_DEPTH];
	logic [mpbm_pkg::RES_PW-1:0]   wr_ptr_q;
	logic [mpbm_pkg::RES_PW-1:0]   rd_ptr_q;
	logic [mpbm_pkg::RES_CW-1:0]   count_q;
	logic                          pop;

	assign valid = (count_q != '0);
	assign item  = slot_q[rd_ptr_q];
	assign count = count_q;
	assign pop   = valid && !stall;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: tb/tb_multi_pattern_byte_matcher.sv
`timescale 1ns / 1ps
// testbench for the multi-pattern byte matcher: loads small automata, scans packets, checks verdicts
module tb_multi_pattern_byte_matcher;
	import mpbm_pkg::*;

	localparam logic [1:0] FN_UNUSED = 2'd3;
	localparam int PHASE_NODES = 6;
	localparam int PHASE_COLS  = 6;
	localparam int ITEM_TARGET = 1850;
	localparam int STUCK_LIMIT = 2000;
	localparam int CMD_W       = $bits(cmd_t);

	class match_tracker;
		logic [NODE_W-1:0] goto_tab [GOTO_DEPTH];
		bit                goto_set [GOTO_DEPTH];
		node_out_t         out_tab [NODE_COUNT];
		bit                out_set [NODE_COUNT];
		logic [NODE_W-1:0] cur_node;
		logic              packet_hit;
		logic [SIG_W-1:0]  hit_sig;
		res_t              expected_res [$];
		int                errors;

		function new();
			cur_node = '0;
			packet_hit = 1'b0;
			hit_sig = '0;
			errors = 0;
		endfunction

		// true when a payload byte from the current node reads only loaded entries, or when the packet already hit
		function bit can_step(logic [BYTE_W-1:0] col);
			logic [GOTO_AW-1:0] idx;
			idx = {cur_node, col};
			return packet_hit || (goto_set[idx] && out_set[goto_tab[idx]]);
		endfunction

		function void take_cmd(cmd_t c);
			logic [GOTO_AW-1:0] idx;
			res_t r;
			idx = {c.node, c.byte_value};
			case (c.func)
				FN_LOAD_GOTO: begin
					if (c.node < NODE_COUNT && c.next_node < NODE_COUNT) begin
						goto_tab[idx] = c.next_node;
						goto_set[idx] = 1'b1;
					end
				end
				FN_LOAD_OUT: begin
					if (c.node < NODE_COUNT) begin
						if (!c.sig_present) begin
							out_tab[c.node] = '0;
							out_set[c.node] = 1'b1;
						end else if (c.sig_value < SIG_COUNT) begin
							out_tab[c.node] = {1'b1, c.sig_value};
							out_set[c.node] = 1'b1;
						end
					end
				end
				FN_BYTE: begin
					if (!packet_hit) begin
						cur_node = goto_tab[{cur_node, c.byte_value}];
						if (out_tab[cur_node].present) begin
							packet_hit = 1'b1;
							hit_sig = out_tab[cur_node].sig;
						end
					end
					if (c.last_byte) begin
						r.matched = packet_hit;
						r.match_sig = packet_hit ? hit_sig : '0;
						expected_res.push_back(r);
						cur_node = '0;
						packet_hit = 1'b0;
						hit_sig = '0;
					end
				end
				default: ;
			endcase
		endfunction

		task report(string msg);
			if (errors < 40)
				$display("mismatch: %s", msg);
			errors++;
		endtask

		task check_res(res_t r);
			res_t e;
			if (expected_res.size() == 0) begin
				report($sformatf("result with none expected: matched=%0d sig=%0d",
					r.matched, r.match_sig));
				return;
			end
			e = expected_res.pop_front();
			if (r.matched !== e.matched)
				report($sformatf("matched got %0d want %0d", r.matched, e.matched));
			if (r.match_sig !== e.match_sig)
				report($sformatf("match_sig got %0d want %0d", r.match_sig, e.match_sig));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	match_tracker tracker = new();
	bit calm;
	bit took;
	int items_taken;
	int stuck;
	logic [NODE_W-1:0] phase_nodes [PHASE_NODES];
	logic [BYTE_W-1:0] phase_cols [PHASE_COLS];

	multi_pattern_byte_matcher u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		res_stall <= !calm && ($urandom_range(0, 99) < 15);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			took = 1'b0;
			if (cmd_valid && cmd_stall === 1'b0) begin
				tracker.take_cmd(cmd);
				took = 1'b1;
				if (cmd.func != FN_UNUSED)
					items_taken++;
			end
			if (res_valid === 1'b1 && res_stall === 1'b0) begin
				tracker.check_res(res);
				took = 1'b1;
			end
			stuck = took ? 0 : stuck + 1;
			if (stuck >= STUCK_LIMIT) begin
				$display("tb_multi_pattern_byte_matcher failed");
				$finish;
			end
		end
	end

	function automatic cmd_t random_cmd();
		logic [CMD_W-1:0] raw;
		raw = CMD_W'({$urandom(), $urandom()});
		return cmd_t'(raw);
	endfunction

	// entered and left at a falling edge; the item stays on the bus until the next call
	task automatic send(cmd_t c);
		while (!calm && $urandom_range(0, 99) < 15) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (cmd_stall !== 1'b0);
		@(negedge clk);
	endtask

	task automatic load_goto(logic [NODE_W-1:0] n, logic [BYTE_W-1:0] col,
		logic [NODE_W-1:0] tgt);
		cmd_t c;
		c = random_cmd();
		c.func = FN_LOAD_GOTO;
		c.node = n;
		c.byte_value = col;
		c.next_node = tgt;
		send(c);
	endtask

	task automatic load_out(logic [NODE_W-1:0] n, logic present, logic [SIG_W-1:0] sig);
		cmd_t c;
		c = random_cmd();
		c.func = FN_LOAD_OUT;
		c.node = n;
		c.sig_present = present;
		c.sig_value = sig;
		send(c);
	endtask

	task automatic send_byte(logic [BYTE_W-1:0] col, logic last);
		cmd_t c;
		c = random_cmd();
		c.func = FN_BYTE;
		c.byte_value = col;
		c.last_byte = last;
		send(c);
	endtask

	task automatic send_noise();
		cmd_t c;
		c = random_cmd();
		c.func = FN_UNUSED;
		send(c);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		do @(negedge clk); while (tracker.expected_res.size() != 0);
	endtask

	task automatic run_directed();
		load_out(10'd0, 1'b0, 4'd0);
		load_out(10'd1023, 1'b1, 4'd15);
		load_out(10'd1, 1'b1, 4'd0);
		load_out(10'd512, 1'b0, 4'd9);
		load_goto(10'd0, 8'h00, 10'd512);
		load_goto(10'd0, 8'hFF, 10'd1023);
		load_goto(10'd0, 8'h55, 10'd1);
		load_goto(10'd512, 8'hAA, 10'd1023);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		// bytes after a hit are ignored
		send_byte(8'h00, 1'b0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h3C, 1'b1);
		send_byte(8'h55, 1'b1);
		send_noise();
		load_out(10'd1023, 1'b1, 4'd7);
		// entry rewritten right before it is read
		load_goto(10'd0, 8'h55, 10'd512);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b1);
		load_out(10'd1023, 1'b0, 4'd15);
		load_goto(10'd512, 8'h00, 10'd0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
	endtask

	task automatic run_packet(int len);
		logic [BYTE_W-1:0] col;
		bit found;
		int k;
		for (int i = 0; i < len; i++) begin
			k = $urandom_range(0, 99);
			if (k < 3)
				send_noise();
			else if (k < 6)
				load_goto(phase_nodes[$urandom_range(0, PHASE_NODES-1)],
					phase_cols[$urandom_range(0, PHASE_COLS-1)],
					phase_nodes[$urandom_range(0, PHASE_NODES-1)]);
			found = 1'b0;
			for (int t = 0; t < 8 && !found; t++) begin
				col = $urandom_range(0, 1) ? phase_cols[$urandom_range(0, PHASE_COLS-1)]
					: 8'($urandom_range(0, 255));
				found = tracker.can_step(col);
			end
			if (!found) begin
				col = phase_cols[$urandom_range(0, PHASE_COLS-1)];
				load_goto(tracker.cur_node, col, phase_nodes[$urandom_range(0, PHASE_NODES-1)]);
			end
			send_byte(col, i == len - 1);
		end
	endtask

	task automatic run_phase(int n_packets);
		logic present;
		phase_nodes[0] = '0;
		for (int i = 1; i < PHASE_NODES; i++)
			phase_nodes[i] = NODE_W'($urandom_range(1, NODE_COUNT - 1));
		for (int i = 0; i < PHASE_COLS; i++)
			phase_cols[i] = BYTE_W'($urandom_range(0, 255));
		for (int i = 0; i < PHASE_NODES; i++) begin
			present = (i == 0) ? ($urandom_range(0, 7) == 0) : ($urandom_range(0, 2) == 0);
			load_out(phase_nodes[i], present, SIG_W'($urandom_range(0, 15)));
		end
		for (int i = 0; i < PHASE_NODES; i++)
			for (int j = 0; j < PHASE_COLS; j++)
				load_goto(phase_nodes[i], phase_cols[j],
					phase_nodes[$urandom_range(0, PHASE_NODES-1)]);
		repeat (n_packets)
			run_packet(($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
				: $urandom_range(1, 6));
	endtask

	initial begin
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		calm = 1'b0;
		items_taken = 0;
		stuck = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		run_directed();
		for (int p = 0; items_taken < ITEM_TARGET; p++) begin
			calm = (p >= 5 && p <= 7);
			run_phase(12);
			if (p % 4 == 3)
				drain();
		end
		calm = 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_res.size() == 0)
			$display("tb_multi_pattern_byte_matcher passed");
		else
			$display("tb_multi_pattern_byte_matcher failed");
		$finish;
	end

endmodule
